// ----- rtl/est_pkg.sv -----
// ----------------------------------------------------------------------------
// est_pkg
// Types, codes and constants shared by the event slot table modules.
// ----------------------------------------------------------------------------
package est_pkg;

   localparam int SLOT_COUNT_DEFAULT = 16;

   localparam logic [31:0] CALLBACK_MODE_WORD = 32'h0000_1000;
   localparam logic [31:0] CLOSED_CLASS       = 32'hFFFF_FFFF;
   localparam logic [5:0]  FULL_REPLY         = 6'd63;

   typedef enum logic [2:0] {
      KIND_OPEN    = 3'd0,
      KIND_CLOSE   = 3'd1,
      KIND_WAIT    = 3'd2,
      KIND_TEST    = 3'd3,
      KIND_ENABLE  = 3'd4,
      KIND_DISABLE = 3'd5,
      KIND_TRIGGER = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MODIFY,
      ST_WALK,
      ST_RESP
   } state_type;

   // one stored slot, kept as a single memory word
   typedef struct packed {
      logic        cb_mode;
      logic        enabled;
      logic        triggered;
      logic [31:0] cls;
      logic [31:0] spec;
      logic [31:0] handler;
   } slot_entry_type;

   typedef struct packed {
      logic hit;
      logic callback;
   } match_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  slot;
      logic [31:0] cls;
      logic [31:0] spec;
      logic [31:0] mode;
      logic [31:0] handler;
   } req_type;

   typedef struct packed {
      logic [5:0]  reply;
      logic        open_failed;
      logic        callback_valid;
      logic [31:0] callback_address;
      logic        last;
   } rsp_type;

endpackage

// ----- rtl/event_slot_table_with_trigger_match_core.sv -----
// ----------------------------------------------------------------------------
// event_slot_table_with_trigger_match_core
// Event slot table: open/close/wait/test/enable/disable on single slots and
// a trigger walk that marks matching slots and emits callback handlers.
// ----------------------------------------------------------------------------
//  channel  dir  ports                 contents
//  req      in   req_t{valid,ready}    tuser: kind; tdata: operands
//  rsp      out  rsp_t{valid,ready}    tuser: callback flag; tdata: reply;
//                                      tlast: final result of a request
//
//  Open, unused kinds and slot ops on a slot that is not open pass from
//  transfer through DECODE and RESP to the result register; slot ops on an
//  open slot add MODIFY (one read-modify-write on the slot memory).
//  Trigger walks the open slots, one slot per cycle unless a stalled
//  callback holds it, through the single read port and compare unit.
//  req_tready is high only while idle; rsp stalls hold the walk at a
//  callback. Reset clears the open count and the handshake state only.
// ----------------------------------------------------------------------------
module event_slot_table_with_trigger_match_core
   import est_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] slot_number, [39:8] class_code, [71:40] spec_code,
   // [103:72] mode_word, [135:104] handler_address
   input  logic [135:0] req_tdata,
   // [2:0] kind
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [5:0] reply, [6] open_failed, [38:7] callback_address, [39] zero
   output logic [39:0]  rsp_tdata,
   // [0] callback_valid
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  open_count_ff, open_count_in;
   logic [ADDR_W-1:0] walk_idx_ff, walk_idx_in;
   rsp_type           pend_ff, pend_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   slot_entry_type    ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   slot_entry_type    ram_rd_data;
   match_type         match;

   est_slot_ram #(
      .DEPTH  (SLOT_COUNT),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   est_match u_match (
      .entry  (ram_rd_data),
      .cls    (req_ff.cls),
      .spec   (req_ff.spec),
      .result (match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         open_count_ff <= open_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      walk_idx_ff <= walk_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      logic             slot_ok;
      logic             can_emit;
      logic [CNT_W-1:0] next_count;
      slot_entry_type   entry;

      state_in      = state_ff;
      req_in        = req_ff;
      open_count_in = open_count_ff;
      walk_idx_in   = walk_idx_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      ram_wr_en   = 1'b0;
      ram_wr_addr = walk_idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = walk_idx_ff;

      req_tready = (state_ff == ST_IDLE);
      slot_ok    = req_ff.slot < 8'(open_count_ff);
      can_emit   = !rsp_valid_ff || rsp_tready;
      next_count = CNT_W'(walk_idx_ff) + CNT_W'(1);
      entry      = ram_rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               req_in.kind    = kind_type'(req_tuser);
               req_in.slot    = req_tdata[7:0];
               req_in.cls     = req_tdata[39:8];
               req_in.spec    = req_tdata[71:40];
               req_in.mode    = req_tdata[103:72];
               req_in.handler = req_tdata[135:104];
               state_in       = ST_DECODE;
            end
         end

         ST_DECODE: begin
            pend_in      = '0;
            pend_in.last = 1'b1;
            state_in     = ST_RESP;
            case (req_ff.kind)
               KIND_OPEN: begin
                  if (open_count_ff >= CNT_W'(SLOT_COUNT)) begin
                     pend_in.reply       = FULL_REPLY;
                     pend_in.open_failed = 1'b1;
                  end else begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = ADDR_W'(open_count_ff);
                     ram_wr_data.cb_mode   = (req_ff.mode == CALLBACK_MODE_WORD);
                     ram_wr_data.enabled   = 1'b0;
                     ram_wr_data.triggered = 1'b0;
                     ram_wr_data.cls       = req_ff.cls;
                     ram_wr_data.spec      = req_ff.spec;
                     ram_wr_data.handler   = req_ff.handler;
                     pend_in.reply         = 6'(open_count_ff);
                     open_count_in         = open_count_ff + CNT_W'(1);
                  end
               end
               KIND_CLOSE, KIND_WAIT, KIND_TEST, KIND_ENABLE, KIND_DISABLE: begin
                  if (slot_ok) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = req_ff.slot[ADDR_W-1:0];
                     state_in    = ST_MODIFY;
                  end
               end
               KIND_TRIGGER: begin
                  walk_idx_in = '0;
                  if (open_count_ff != '0) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = ST_WALK;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_MODIFY: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = req_ff.slot[ADDR_W-1:0];
            pend_in.reply = 6'd1;
            case (req_ff.kind)
               KIND_CLOSE: begin
                  entry.enabled = 1'b0;
                  entry.cls     = CLOSED_CLASS;
               end
               KIND_WAIT: begin
                  entry.triggered = 1'b0;
               end
               KIND_TEST: begin
                  pend_in.reply   = {5'd0, entry.triggered};
                  entry.triggered = 1'b0;
               end
               KIND_ENABLE: begin
                  entry.enabled = 1'b1;
               end
               default: begin
                  entry.enabled = 1'b0;
               end
            endcase
            ram_wr_data = entry;
            state_in    = ST_RESP;
         end

         ST_WALK: begin
            // a callback waits here until the output register is free
            if (!match.callback || can_emit) begin
               if (match.hit) begin
                  ram_wr_en             = 1'b1;
                  ram_wr_addr           = walk_idx_ff;
                  ram_wr_data.triggered = 1'b1;
               end
               if (match.callback) begin
                  rsp_in                  = '0;
                  rsp_in.callback_valid   = 1'b1;
                  rsp_in.callback_address = ram_rd_data.handler;
                  rsp_valid_in            = 1'b1;
               end
               if (next_count < open_count_ff) begin
                  walk_idx_in = ADDR_W'(next_count);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ADDR_W'(next_count);
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_RESP: begin
            if (can_emit) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.callback_address, rsp_ff.open_failed, rsp_ff.reply};
   assign rsp_tuser  = rsp_ff.callback_valid;
   assign rsp_tlast  = rsp_ff.last;

endmodule

// ----- rtl/est_slot_ram.sv -----
// ----------------------------------------------------------------------------
// est_slot_ram
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module est_slot_ram
   import est_pkg::*;
#(
   parameter int DEPTH  = SLOT_COUNT_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  slot_entry_type      wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output slot_entry_type      rd_data
);

   slot_entry_type slots_ff [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slots_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/est_match.sv -----
// ----------------------------------------------------------------------------
// est_match
// Compare unit: tests one stored slot against the trigger class and spec.
// ----------------------------------------------------------------------------
module est_match
   import est_pkg::*;
(
   input  slot_entry_type entry,
   input  logic [31:0]    cls,
   input  logic [31:0]    spec,
   output match_type      result
);

   always_comb begin
      result.hit      = entry.enabled && (entry.cls == cls) && (entry.spec == spec);
      result.callback = result.hit && entry.cb_mode && (entry.handler != 32'd0);
   end

endmodule

// ----- rtl/est_checker.sv -----
// ----------------------------------------------------------------------------
// est_checker
// Port-level checks on the event slot table, bound to the top level.
// ----------------------------------------------------------------------------
module est_checker
   import est_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in progress");

   a_callback_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser || !rsp_tlast) |->
         rsp_tuser && !rsp_tlast && rsp_tdata[5:0] == 6'd0 &&
         rsp_tdata[6] == 1'b0 && rsp_tdata[38:7] != 32'd0)
      else $error("malformed callback transfer");

   a_open_failed_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> rsp_tdata[5:0] == FULL_REPLY && rsp_tlast)
      else $error("malformed open failure transfer");

endmodule

bind event_slot_table_with_trigger_match_core est_checker u_est_checker (.*);
